[src/mec_pkg.sv]
package mec_pkg;

   // fixed word widths
   localparam int DATA_W = 32;        // Q4.28 words
   localparam int WIDE_W = 66;        // headroom for sums before saturation
   localparam int PROD_W = 2 * DATA_W;
   localparam int CNT_W  = 16;
   localparam int GRAY_W = 8;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register file
   localparam int ADDR_W    = 5;
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_X_STEP   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

   localparam logic signed [DATA_W-1:0] X_ORIGIN_RST = -32'sd536870912;
   localparam logic signed [DATA_W-1:0] Y_ORIGIN_RST = -32'sd402653184;
   localparam logic signed [DATA_W-1:0] X_STEP_RST   = 32'sd786432;
   localparam logic signed [DATA_W-1:0] Y_STEP_RST   = 32'sd786432;
   localparam logic [CNT_W-1:0]         MAX_ITER_RST = 16'd256;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_origin;
      logic signed [DATA_W-1:0] y_origin;
      logic signed [DATA_W-1:0] x_step;
      logic signed [DATA_W-1:0] y_step;
   } coord_cfg_type;

   // one queued point c = cr + i*ci
   typedef struct packed {
      logic signed [DATA_W-1:0] cr;
      logic signed [DATA_W-1:0] ci;
   } point_type;

   localparam logic signed [WIDE_W-1:0] WIDE_MAX =
      {{(WIDE_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MIN =
      {{(WIDE_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

   // clamp to the signed word range
   function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > WIDE_MAX) begin
         r = {1'b0, {(DATA_W - 1){1'b1}}};
      end else if (v < WIDE_MIN) begin
         r = {1'b1, {(DATA_W - 1){1'b0}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

[src/mec_req_if.sv]
interface mec_req_if #(
   parameter int COORD_BITS = 12
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

[src/mec_rsp_if.sv]
interface mec_rsp_if ();
   import mec_pkg::*;

   logic              valid;
   logic              ready;
   logic [CNT_W-1:0]  escape_count;
   logic [GRAY_W-1:0] gray_level;

   modport source (output valid, output escape_count, output gray_level, input ready);
   modport sink   (input valid, input escape_count, input gray_level, output ready);
endinterface

[src/mandelbrot_escape_count_unit.sv]
// Channel   | Dir | Handshake        | Payload
// ----------+-----+------------------+-----------------------------------------
// req_ch    | in  | valid / ready    | pixel_x, pixel_y (COORD_BITS each)
// rsp_ch    | out | valid / ready    | escape_count (16), gray_level (8)
// csr (APB) | in  | psel/penable     | paddr (5), pwdata/prdata (32), pready=1
//
// Flow: the front forms c in a registered multiply stage per item; the back
// engine runs each counted step as multiply, then check/update, and a final
// check and a reload in idle close the item; it takes new points only in idle.
// Reset: synchronous, active high; config and state registers return to defaults.
// Stalls: a two-entry queue decouples front and back; a held result blocks
// only the back engine's final step, the front keeps taking items until the
// queue and its own stage are full.
module mandelbrot_escape_count_unit #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 28
) (
   input  logic                       clock,
   input  logic                       reset,
   mec_req_if.sink                    req_ch,
   mec_rsp_if.source                  rsp_ch,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mec_pkg::ADDR_W-1:0] paddr,
   input  logic [mec_pkg::DATA_W-1:0] pwdata,
   output logic [mec_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import mec_pkg::*;

   // ---------------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------------
   logic signed [DATA_W-1:0] x_origin_ff, y_origin_ff, x_step_ff, y_step_ff;
   logic [CNT_W-1:0]         max_iter_ff;
   logic                     wr_en;
   logic [REG_IDX_W-1:0]     reg_idx;
   coord_cfg_type            cfg;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= X_ORIGIN_RST;
         y_origin_ff <= Y_ORIGIN_RST;
         x_step_ff   <= X_STEP_RST;
         y_step_ff   <= Y_STEP_RST;
         max_iter_ff <= MAX_ITER_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_X_ORIGIN: x_origin_ff <= pwdata;
            REG_Y_ORIGIN: y_origin_ff <= pwdata;
            REG_X_STEP:   x_step_ff   <= pwdata;
            REG_Y_STEP:   y_step_ff   <= pwdata;
            REG_MAX_ITER: max_iter_ff <= pwdata[CNT_W-1:0];
            default: ;    // unmapped addresses ignore writes
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_X_ORIGIN: prdata = x_origin_ff;
         REG_Y_ORIGIN: prdata = y_origin_ff;
         REG_X_STEP:   prdata = x_step_ff;
         REG_Y_STEP:   prdata = y_step_ff;
         REG_MAX_ITER: prdata = DATA_W'(max_iter_ff);
         default:      prdata = '0;
      endcase
   end

   assign cfg.x_origin = x_origin_ff;
   assign cfg.y_origin = y_origin_ff;
   assign cfg.x_step   = x_step_ff;
   assign cfg.y_step   = y_step_ff;

   // ---------------------------------------------------------------------
   // Front: pixel -> c
   // ---------------------------------------------------------------------
   logic      push_valid, push_ready, pop_valid, pop_ready;
   point_type push_data, pop_data;

   mec_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // ---------------------------------------------------------------------
   // Point queue
   // ---------------------------------------------------------------------
   mec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // ---------------------------------------------------------------------
   // Back: escape-time iteration and result register
   // ---------------------------------------------------------------------
   mec_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .iter_limit (max_iter_ff),
      .rsp_ch     (rsp_ch)
   );

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // nothing comes out in the cycle after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");

   // a count never reaches the bound (zero when the bound is tiny)
   a_count_below_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.escape_count == '0 || rsp_ch.escape_count < max_iter_ff))
      else $error("escape count at or above iteration bound");

   // gray level is the low byte of the count
   a_gray_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.gray_level == rsp_ch.escape_count[GRAY_W-1:0]))
      else $error("gray level does not match escape count");

   // front keeps its point while the queue is full
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !push_ready) |=> push_valid)
      else $error("front dropped a point while queue full");

endmodule

[src/mec_front.sv]
// Maps a pixel to its point c: multiply stage, then add origin and clamp into the queue.
module mec_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   mec_req_if.sink                req_ch,
   input  mec_pkg::coord_cfg_type cfg,
   output logic                   push_valid,
   output mec_pkg::point_type     push_data,
   input  logic                   push_ready
);
   import mec_pkg::*;

   localparam int CPROD_W = COORD_BITS + 1 + DATA_W;

   logic                      prod_vld_ff;
   logic signed [CPROD_W-1:0] prod_x_ff, prod_x_in;
   logic signed [CPROD_W-1:0] prod_y_ff, prod_y_in;
   logic                      accept;

   assign req_ch.ready = !prod_vld_ff || push_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign prod_x_in = $signed({1'b0, req_ch.pixel_x}) * cfg.x_step;
   assign prod_y_in = $signed({1'b0, req_ch.pixel_y}) * cfg.y_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         prod_vld_ff <= req_ch.valid;
      end
      if (accept) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
   end

   assign push_valid   = prod_vld_ff;
   assign push_data.cr = sat_word(WIDE_W'(cfg.x_origin) + WIDE_W'(prod_x_ff));
   assign push_data.ci = sat_word(WIDE_W'(cfg.y_origin) + WIDE_W'(prod_y_ff));

endmodule

[src/mec_queue.sv]
// Small register FIFO of points between front and back.
module mec_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  mec_pkg::point_type push_data,
   output logic               push_ready,
   output logic               pop_valid,
   output mec_pkg::point_type pop_data,
   input  logic               pop_ready
);
   import mec_pkg::*;

   point_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   assign wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/mec_back.sv]
// Iteration engine: each step is a multiply state followed by a check/update state.
module mec_back #(
   parameter int FRAC_BITS = 28
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   input  mec_pkg::point_type        pop_data,
   output logic                      pop_ready,
   input  logic [mec_pkg::CNT_W-1:0] iter_limit,
   mec_rsp_if.source                 rsp_ch
);
   import mec_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_UPD} state_type;

   localparam logic signed [WIDE_W-1:0] FOUR = WIDE_W'(4) << FRAC_BITS;

   state_type                state_ff;
   logic signed [DATA_W-1:0] cr_ff, ci_ff;
   logic signed [DATA_W-1:0] zr_ff, zi_ff, zr_in, zi_in;
   logic signed [PROD_W-1:0] sq_r_ff, sq_i_ff, cross_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     rsp_vld_ff, rsp_vld_in;
   logic [CNT_W-1:0]         rsp_cnt_ff;

   logic signed [WIDE_W-1:0] zr2, zi2, zrzi, mag;
   logic                     escaped, last, finish, out_free, rsp_load;

   assign pop_ready = (state_ff == ST_IDLE);

   // products scaled back to the word's binary point (floor)
   assign zr2  = WIDE_W'(sq_r_ff >>> FRAC_BITS);
   assign zi2  = WIDE_W'(sq_i_ff >>> FRAC_BITS);
   assign zrzi = WIDE_W'(cross_ff >>> FRAC_BITS);
   assign mag  = zr2 + zi2;

   assign escaped  = (mag >= FOUR);
   // step number is count + 1; stop once it reaches the bound
   assign last     = (({1'b0, count_ff} + 17'd1) >= {1'b0, iter_limit});
   assign finish   = escaped || last;
   assign out_free = !rsp_vld_ff || rsp_ch.ready;

   // result register: loads on the final step, clears when taken
   assign rsp_load   = (state_ff == ST_UPD) && finish && out_free;
   assign rsp_vld_in = rsp_load || (rsp_vld_ff && !rsp_ch.ready);

   assign zr_in = sat_word(zr2 - zi2 + WIDE_W'(cr_ff));
   assign zi_in = sat_word((zrzi <<< 1) + WIDE_W'(ci_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  cr_ff    <= pop_data.cr;
                  ci_ff    <= pop_data.ci;
                  zr_ff    <= '0;
                  zi_ff    <= '0;
                  count_ff <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               sq_r_ff  <= zr_ff * zr_ff;
               sq_i_ff  <= zi_ff * zi_ff;
               cross_ff <= zr_ff * zi_ff;
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               if (finish) begin
                  // hold here until the output register frees up
                  if (out_free) begin
                     rsp_cnt_ff <= count_ff;
                     state_ff   <= ST_IDLE;
                  end
               end else begin
                  count_ff <= count_ff + 1'b1;
                  zr_ff    <= zr_in;
                  zi_ff    <= zi_in;
                  state_ff <= ST_MUL;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.escape_count = rsp_cnt_ff;
   assign rsp_ch.gray_level   = rsp_cnt_ff[GRAY_W-1:0];

endmodule
